// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CLR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/clr_pkg.sv -----
// ----------------------------------------------------------------------------
// clr_pkg
// types and constants shared by the combination rank block
// ----------------------------------------------------------------------------
package clr_pkg;

  // largest ground set the binomial table covers
  localparam int MAX_SET   = 33;
  localparam int TBL_DIM   = MAX_SET + 1;
  localparam int TBL_DEPTH = TBL_DIM * TBL_DIM;
  localparam int ADDR_W    = $clog2(TBL_DEPTH);
  localparam int IDX_W     = $clog2(TBL_DIM);
  localparam int FIELD_W   = 6;
  localparam int RANK_W    = 31;

  // input beat
  typedef struct packed {
    logic [FIELD_W-1:0] element;
    logic [FIELD_W-1:0] set_size;
    logic [FIELD_W-1:0] subset_length;
    logic               is_last;
  } clr_in_t;

  // result beat
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              bad_input;
  } clr_out_t;

  // table write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [RANK_W-1:0] data;
  } clr_wr_t;

  // rank sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_END
  } clr_state_t;

endpackage

// ----- rtl/core/clr_binom_ram.sv -----
// ----------------------------------------------------------------------------
// clr_binom_ram
// binomial table storage: one write port, two registered read ports
// ----------------------------------------------------------------------------
module clr_binom_ram
  import clr_pkg::*;
(
  input  logic              clk,
  input  clr_wr_t           wr,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [RANK_W-1:0] rd_data_a,
  output logic [RANK_W-1:0] rd_data_b
);

  logic [RANK_W-1:0] mem [TBL_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- rtl/core/clr_fill.sv -----
// ----------------------------------------------------------------------------
// clr_fill
// builds the pascal triangle in the table after reset, one entry per cycle
// ----------------------------------------------------------------------------
module clr_fill
  import clr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [RANK_W-1:0] rd_data_a,
  input  logic [RANK_W-1:0] rd_data_b,
  output logic [ADDR_W-1:0] rd_addr_a,
  output logic [ADDR_W-1:0] rd_addr_b,
  output clr_wr_t           wr,
  output logic              busy,
  output logic              done
);

  logic              issuing;
  logic [IDX_W-1:0]  row;
  logic [IDX_W-1:0]  col;
  logic [ADDR_W-1:0] addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_row;
  logic [IDX_W-1:0]  wr_col;
  logic [ADDR_W-1:0] wr_addr;

  // upper-left and upper neighbors in the previous row
  assign rd_addr_a = addr - ADDR_W'(TBL_DIM + 1);
  assign rd_addr_b = addr - ADDR_W'(TBL_DIM);

  // read sweep over all rows and columns
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b1;
      row     <= '0;
      col     <= '0;
      addr    <= '0;
      wr_en   <= 1'b0;
    end else begin
      wr_en <= issuing;
      if (issuing) begin
        addr <= addr + ADDR_W'(1);
        if (col == IDX_W'(TBL_DIM - 1)) begin
          col <= '0;
          if (row == IDX_W'(TBL_DIM - 1)) begin
            issuing <= 1'b0;
          end else begin
            row <= row + IDX_W'(1);
          end
        end else begin
          col <= col + IDX_W'(1);
        end
      end
    end
  end

  // write stage follows the read in the next cycle
  always_ff @(posedge clk) begin
    wr_row  <= row;
    wr_col  <= col;
    wr_addr <= addr;
  end

  // edge of the triangle is one, above the diagonal is zero
  always_comb begin
    wr.en   = wr_en;
    wr.addr = wr_addr;
    if (wr_col == '0) begin
      wr.data = RANK_W'(1);
    end else if (wr_col > wr_row) begin
      wr.data = '0;
    end else begin
      wr.data = rd_data_a + rd_data_b;
    end
  end

  assign busy = issuing | wr_en;
  assign done = ~busy;

endmodule

// ----- rtl/core/clr_rank.sv -----
// ----------------------------------------------------------------------------
// clr_rank
// per-element sequencer: checks the element, walks the skipped values through
// the binomial table and accumulates the rank
// ----------------------------------------------------------------------------
module clr_rank
  import clr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              fill_done,
  input  logic              in_valid,
  output logic              in_ready,
  input  clr_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output clr_out_t          out_data,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [RANK_W-1:0] rd_data
);

  clr_state_t         state;
  clr_state_t         state_next;
  logic [FIELD_W-1:0] position;
  logic [FIELD_W-1:0] next_candidate;
  logic [RANK_W-1:0]  rank_sum;
  logic [FIELD_W-1:0] held_set_size;
  logic [FIELD_W-1:0] held_length;
  logic               error_seen;
  logic [FIELD_W-1:0] target;
  logic [FIELD_W-1:0] col;
  logic               last;
  logic [FIELD_W-1:0] walk_j;
  logic               rd_pend;

  logic               accept;
  logic               load_out;
  logic               pos_zero;
  logic [FIELD_W-1:0] n_cur;
  logic [FIELD_W-1:0] k_cur;
  logic               err_cur;
  logic [FIELD_W-1:0] col_cur;
  logic               need_walk;
  logic               err_final;
  logic [FIELD_W-1:0] row;

  // checks on the incoming element
  always_comb begin
    pos_zero  = (position == '0);
    n_cur     = pos_zero ? in_data.set_size : held_set_size;
    k_cur     = pos_zero ? in_data.subset_length : held_length;
    err_cur   = error_seen
              | (pos_zero & (in_data.set_size > FIELD_W'(MAX_SET)))
              | (position >= k_cur)
              | (in_data.element < next_candidate)
              | (in_data.element >= n_cur);
    col_cur   = k_cur - position - FIELD_W'(1);
    need_walk = ~err_cur & (col_cur < FIELD_W'(TBL_DIM))
              & (in_data.element != next_candidate);
    err_final = error_seen | (position != held_length);
  end

  // table address for C(n-j-1, col)
  assign row     = held_set_size - walk_j - FIELD_W'(1);
  assign rd_addr = ADDR_W'(row) * ADDR_W'(TBL_DIM) + ADDR_W'(col);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = fill_done;
        if (in_valid && fill_done) begin
          state_next = need_walk ? ST_WALK : ST_END;
        end
      end
      ST_WALK: begin
        if (walk_j == target) begin
          state_next = ST_END;
        end
      end
      ST_END: begin
        if (!last) begin
          state_next = ST_IDLE;
        end else if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = in_valid & in_ready;

  // per-item payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      target <= in_data.element;
      col    <= col_cur;
      last   <= in_data.is_last;
      walk_j <= next_candidate;
    end else if (state == ST_WALK && walk_j != target) begin
      walk_j <= walk_j + FIELD_W'(1);
    end
  end

  // sequence state and accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      next_candidate <= '0;
      rank_sum       <= '0;
      held_set_size  <= '0;
      held_length    <= '0;
      error_seen     <= 1'b0;
      rd_pend        <= 1'b0;
    end else if (accept) begin
      if (pos_zero) begin
        held_set_size <= in_data.set_size;
        held_length   <= in_data.subset_length;
      end
      error_seen <= err_cur;
      if (!err_cur) begin
        next_candidate <= in_data.element + FIELD_W'(1);
      end
      if (position != '1) begin
        position <= position + FIELD_W'(1);
      end
      rd_pend <= 1'b0;
    end else if (state == ST_WALK) begin
      rd_pend <= (walk_j != target);
      if (rd_pend) begin
        rank_sum <= rank_sum + rd_data;
      end
    end else if (load_out) begin
      position       <= '0;
      next_candidate <= '0;
      rank_sum       <= '0;
      held_set_size  <= '0;
      held_length    <= '0;
      error_seen     <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.rank      <= err_final ? '0 : rank_sum;
      out_data.bad_input <= err_final;
    end
  end

endmodule

// ----- rtl/core/combination_lex_rank.sv -----
// ----------------------------------------------------------------------------
// combination_lex_rank
// lexicographic rank of a strictly increasing k-subset of {0..n-1}
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_data carries one subset element per beat;
// set_size and subset_length are taken from the first beat of each subset and
// is_last marks its final element. Output channel out_valid/out_ready/out_data
// carries one beat per subset, after the last element: the rank, or rank 0
// with bad_input set when the subset was malformed.
// After reset the binomial table is built, one entry per cycle; in_ready stays
// low until it is done. An element with skipped values to walk passes through
// ST_WALK before ST_END; an element with nothing to walk (no skipped value, a
// malformed element, or a column past the table) goes straight to ST_END.
// The table has one read port for the walk, so the skipped values are looked
// up one at a time, and the next element is taken only back in ST_IDLE. The
// last element's result is loaded into the output register in ST_END.
// The result sits in an output register; new elements are still taken while
// it waits, and only the next subset's result waits for out_ready.
// ----------------------------------------------------------------------------
module combination_lex_rank
  import clr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  clr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output clr_out_t out_data
);

  logic              fill_busy;
  logic              fill_done;
  logic [ADDR_W-1:0] fill_addr_a;
  logic [ADDR_W-1:0] fill_addr_b;
  logic [ADDR_W-1:0] rank_addr;
  logic [ADDR_W-1:0] ram_addr_a;
  logic [RANK_W-1:0] ram_data_a;
  logic [RANK_W-1:0] ram_data_b;
  clr_wr_t           wr;

  // table builder owns port a while it runs
  assign ram_addr_a = fill_busy ? fill_addr_a : rank_addr;

  clr_binom_ram u_ram (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (ram_addr_a),
    .rd_addr_b (fill_addr_b),
    .rd_data_a (ram_data_a),
    .rd_data_b (ram_data_b)
  );

  clr_fill u_fill (
    .clk       (clk),
    .rst       (rst),
    .rd_data_a (ram_data_a),
    .rd_data_b (ram_data_b),
    .rd_addr_a (fill_addr_a),
    .rd_addr_b (fill_addr_b),
    .wr        (wr),
    .busy      (fill_busy),
    .done      (fill_done)
  );

  clr_rank u_rank (
    .clk       (clk),
    .rst       (rst),
    .fill_done (fill_done),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .rd_addr   (rank_addr),
    .rd_data   (ram_data_a)
  );

endmodule

// ----- rtl/core/clr_checker.sv -----
// ----------------------------------------------------------------------------
// clr_checker
// port-level checks on the combination rank block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clr_checker
  import clr_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input clr_out_t out_data
);

  // a stalled result beat stays up
  `CLR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // a stalled result beat keeps its payload
  `CLR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))

  // a malformed subset always reports rank zero
  `CLR_ASSERT_NOW(a_bad_zero, out_valid && out_data.bad_input, out_data.rank == '0)

  // table build keeps the input closed right after reset
  `CLR_ASSERT_NOW(a_fill_gate, $past(rst), !in_ready)

  // one element at a time: input closes after each beat
  `CLR_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind combination_lex_rank clr_checker u_chk (.*);
